@@ src/mtop_pkg.sv @@
`timescale 1ns / 1ps
package mtop_pkg;

  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_START  = 2'd1;
  localparam logic [1:0] OP_STOP   = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [2:0] EV_STARTED   = 3'd0;
  localparam logic [2:0] EV_START_REF = 3'd1;
  localparam logic [2:0] EV_START_IGN = 3'd2;
  localparam logic [2:0] EV_STOPPED   = 3'd3;
  localparam logic [2:0] EV_STOP_REF  = 3'd4;
  localparam logic [2:0] EV_TIMEOUT   = 3'd5;
  localparam logic [2:0] EV_TICK_DONE = 3'd6;

  // -2^32 in 34-bit two's complement
  localparam logic [33:0] REM_MIN_W = 34'h3_0000_0000;

  typedef struct packed {
    logic latch;
    logic do_start;
    logic do_stop;
    logic walk_issue;
    logic do_free;
  } cmd_t;

  typedef struct packed {
    logic walk_end;
  } status_t;

endpackage

@@ src/mtop_ctrl.sv @@
`timescale 1ns / 1ps
module mtop_ctrl import mtop_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [1:0] operation,
  input  status_t    status,
  output logic       busy,
  output cmd_t       cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC_START,
    S_EXEC_STOP,
    S_WALK,
    S_LAST,
    S_FREE
  } state_t;

  state_t state;
  logic   accept;

  assign accept = start && !busy;

  always_comb begin
    cmd            = '0;
    cmd.latch      = (state == S_IDLE) && accept;
    cmd.do_start   = (state == S_EXEC_START);
    cmd.do_stop    = (state == S_EXEC_STOP);
    cmd.walk_issue = (state == S_WALK);
    cmd.do_free    = (state == S_FREE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (operation)
              OP_TICK: begin
                state <= S_WALK;
                busy  <= 1'b1;
              end
              OP_START: begin
                state <= S_EXEC_START;
                busy  <= 1'b1;
              end
              OP_STOP: begin
                state <= S_EXEC_STOP;
                busy  <= 1'b1;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_EXEC_START, S_EXEC_STOP: begin
          state <= S_IDLE;
          busy  <= 1'b0;
        end
        S_WALK: begin
          if (status.walk_end) begin
            state <= S_LAST;
          end
        end
        S_LAST: begin
          state <= S_FREE;
        end
        S_FREE: begin
          state <= S_IDLE;
          busy  <= 1'b0;
        end
        default: begin
          state <= S_IDLE;
          busy  <= 1'b0;
        end
      endcase
    end
  end

endmodule

@@ src/mtop_datapath.sv @@
`timescale 1ns / 1ps
module mtop_datapath import mtop_pkg::*; #(
  parameter int NUM_TIMERS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  input  logic [3:0]  timer_id,
  input  logic [15:0] elapsed_ms,
  input  logic [30:0] initial_remaining,
  input  logic [30:0] interval_ms,
  input  logic        periodic,
  output status_t     status,
  output logic        result_strobe,
  output logic [3:0]  timer_id_out,
  output logic [2:0]  event_res,
  output logic        last
);

  localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam logic [8:0] NUM_W = 9'(NUM_TIMERS);

  // slot store
  logic [32:0] rem_mem [NUM_TIMERS];
  logic [30:0] int_mem [NUM_TIMERS];
  logic        per_mem [NUM_TIMERS];

  logic [NUM_TIMERS-1:0] present;
  logic [NUM_TIMERS-1:0] pending;

  // latched transaction
  logic [3:0]  l_id;
  logic [15:0] l_elapsed;
  logic [30:0] l_init;
  logic [30:0] l_int;
  logic        l_per;

  // walk
  logic [IDX_W-1:0] wcnt;
  logic             s1_vld;
  logic [IDX_W-1:0] s1_idx;
  logic [32:0]      rd_rem;
  logic [30:0]      rd_int;
  logic             rd_per;

  logic [IDX_W-1:0] sidx;
  logic             in_range;
  logic             start_ok;
  logic             stop_ok;
  logic             s1_live;
  logic [33:0]      diff;
  logic [32:0]      satr;
  logic             neg;
  logic [32:0]      newr;

  assign sidx     = IDX_W'(l_id);
  assign in_range = 9'(l_id) < NUM_W;
  assign start_ok = in_range && !present[sidx];
  assign stop_ok  = in_range && present[sidx] && !pending[sidx];
  assign s1_live  = s1_vld && present[s1_idx];

  assign diff = {rd_rem[32], rd_rem} - {18'd0, l_elapsed};
  assign satr = ($signed(diff) < $signed(REM_MIN_W)) ? REM_MIN_W[32:0] : diff[32:0];
  assign neg  = satr[32];
  assign newr = neg ? (satr + {2'b00, rd_int}) : satr;

  assign status.walk_end = (wcnt == IDX_W'(NUM_TIMERS - 1));

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      l_id      <= timer_id;
      l_elapsed <= elapsed_ms;
      l_init    <= initial_remaining;
      l_int     <= interval_ms;
      l_per     <= periodic;
    end
  end

  // memory write port
  always_ff @(posedge clk) begin
    if (cmd.do_start && start_ok) begin
      rem_mem[sidx] <= {2'b00, l_init};
      int_mem[sidx] <= l_int;
      per_mem[sidx] <= l_per;
    end else if (s1_live) begin
      rem_mem[s1_idx] <= newr;
    end
  end

  // memory read port
  always_ff @(posedge clk) begin
    if (cmd.walk_issue) begin
      rd_rem <= rem_mem[wcnt];
      rd_int <= int_mem[wcnt];
      rd_per <= per_mem[wcnt];
      s1_idx <= wcnt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wcnt   <= '0;
      s1_vld <= 1'b0;
    end else begin
      s1_vld <= cmd.walk_issue;
      if (cmd.latch) begin
        wcnt <= '0;
      end else if (cmd.walk_issue) begin
        wcnt <= wcnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      present <= '0;
      pending <= '0;
    end else begin
      if (cmd.do_start && start_ok) begin
        present[sidx] <= 1'b1;
        pending[sidx] <= 1'b0;
      end
      if (cmd.do_stop && stop_ok) begin
        pending[sidx] <= 1'b1;
      end
      if (s1_live && neg && !rd_per) begin
        pending[s1_idx] <= 1'b1;
      end
      if (cmd.do_free) begin
        present <= present & ~pending;
        pending <= '0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= cmd.do_start || cmd.do_stop || cmd.do_free || (s1_live && neg);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.do_start) begin
      timer_id_out <= l_id;
      last         <= 1'b1;
      if (!in_range) begin
        event_res <= EV_START_REF;
      end else if (present[sidx] && !pending[sidx]) begin
        event_res <= EV_START_REF;
      end else if (present[sidx]) begin
        event_res <= EV_START_IGN;
      end else begin
        event_res <= EV_STARTED;
      end
    end else if (cmd.do_stop) begin
      timer_id_out <= l_id;
      last         <= 1'b1;
      event_res    <= stop_ok ? EV_STOPPED : EV_STOP_REF;
    end else if (cmd.do_free) begin
      timer_id_out <= 4'd0;
      last         <= 1'b1;
      event_res    <= EV_TICK_DONE;
    end else if (s1_live && neg) begin
      timer_id_out <= 4'(s1_idx);
      last         <= 1'b0;
      event_res    <= EV_TIMEOUT;
    end
  end

endmodule

@@ src/multi_timer_oneshot_periodic.sv @@
`timescale 1ns / 1ps
// Timer table of NUM_TIMERS slots. Start and stop transactions are accepted from the
// idle state and carried out in an execute state; the result is registered from the
// execute state. A tick walks the slot memory one slot per cycle through a single
// read port, then frees the marked slots; busy stays high until the slots are freed
// and one transaction is in flight at a time. Timeout results come out in slot order,
// at most one per cycle, followed by the tick done result with last set. Results are
// shown for a single cycle on result_strobe and cannot be held off by the receiver.
module multi_timer_oneshot_periodic import mtop_pkg::*; #(
  parameter int NUM_TIMERS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  operation,
  input  logic [3:0]  timer_id,
  input  logic [15:0] elapsed_ms,
  input  logic [30:0] initial_remaining,
  input  logic [30:0] interval_ms,
  input  logic        periodic,
  output logic        result_strobe,
  output logic [3:0]  timer_id_out,
  output logic [2:0]  event_res,
  output logic        last
);

  cmd_t    cmd;
  status_t status;

  mtop_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operation (operation),
    .status    (status),
    .busy      (busy),
    .cmd       (cmd)
  );

  mtop_datapath #(
    .NUM_TIMERS (NUM_TIMERS)
  ) u_datapath (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .timer_id          (timer_id),
    .elapsed_ms        (elapsed_ms),
    .initial_remaining (initial_remaining),
    .interval_ms       (interval_ms),
    .periodic          (periodic),
    .status            (status),
    .result_strobe     (result_strobe),
    .timer_id_out      (timer_id_out),
    .event_res         (event_res),
    .last              (last)
  );

endmodule

@@ src/mtop_checker.sv @@
`timescale 1ns / 1ps
module mtop_checker import mtop_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic [1:0] operation,
  input logic       result_strobe,
  input logic [3:0] timer_id_out,
  input logic [2:0] event_res,
  input logic       last
);

  logic accept;
  assign accept = start && !busy;

  a_single_result: assert property (@(posedge clk) disable iff (rst)
    accept && (operation == OP_START || operation == OP_STOP)
      |-> ##2 (result_strobe && last))
    else $error("start or stop transaction without its result");

  a_timeout_in_tick: assert property (@(posedge clk) disable iff (rst)
    result_strobe && !last |-> busy && event_res == EV_TIMEOUT)
    else $error("intermediate result outside a tick");

  a_done_fields: assert property (@(posedge clk) disable iff (rst)
    result_strobe && event_res == EV_TICK_DONE |-> last && timer_id_out == 4'd0)
    else $error("tick done result malformed");

  a_gap_after_last: assert property (@(posedge clk) disable iff (rst)
    result_strobe && last |=> !result_strobe)
    else $error("result directly after a final result");

  a_unused_op: assert property (@(posedge clk) disable iff (rst)
    accept && operation == OP_UNUSED |=> !busy && !result_strobe)
    else $error("unused operation had an effect");

endmodule

bind multi_timer_oneshot_periodic mtop_checker u_mtop_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .operation     (operation),
  .result_strobe (result_strobe),
  .timer_id_out  (timer_id_out),
  .event_res     (event_res),
  .last          (last)
);

@@ bench/multi_timer_oneshot_periodic_test.sv @@
`timescale 1ns / 1ps
module multi_timer_oneshot_periodic_test;
  import mtop_pkg::*;

  localparam longint REM_FLOOR = -64'sd4294967296;
  localparam int SLOTS = 16;
  localparam int SOAK_TICKS = 16;

  typedef struct packed {
    logic [3:0] slot;
    logic [2:0] code;
    logic       last_flag;
  } timer_event_t;

  class timer_event_board;
    longint         remaining [SLOTS];
    bit [30:0]      reload [SLOTS];
    bit             repeats [SLOTS];
    bit             present [SLOTS];
    bit             doomed [SLOTS];
    timer_event_t   due_events [$];
    int             mismatch_count;

    task report_mismatch(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatch_count++;
    endtask

    function void queue_event(logic [3:0] slot, logic [2:0] code, logic last_flag);
      due_events.push_back({slot, code, last_flag});
    endfunction

    function void predict_events(logic [1:0] op, logic [3:0] id, logic [15:0] elapsed,
                                 logic [30:0] init_rem, logic [30:0] ival, logic per);
      longint r;
      case (op)
        OP_START: begin
          if (present[id] && !doomed[id]) begin
            queue_event(id, EV_START_REF, 1'b1);
          end else if (present[id]) begin
            queue_event(id, EV_START_IGN, 1'b1);
          end else begin
            remaining[id] = longint'(init_rem);
            reload[id] = ival;
            repeats[id] = per;
            present[id] = 1'b1;
            doomed[id] = 1'b0;
            queue_event(id, EV_STARTED, 1'b1);
          end
        end
        OP_STOP: begin
          if (present[id] && !doomed[id]) begin
            doomed[id] = 1'b1;
            queue_event(id, EV_STOPPED, 1'b1);
          end else begin
            queue_event(id, EV_STOP_REF, 1'b1);
          end
        end
        OP_TICK: begin
          // pending slots still take part in the walk
          for (int i = 0; i < SLOTS; i++) begin
            if (present[i]) begin
              r = remaining[i] - longint'(elapsed);
              if (r < REM_FLOOR) r = REM_FLOOR;
              if (r < 0) begin
                queue_event(4'(i), EV_TIMEOUT, 1'b0);
                r = r + longint'(reload[i]);
                if (!repeats[i]) doomed[i] = 1'b1;
              end
              remaining[i] = r;
            end
          end
          for (int i = 0; i < SLOTS; i++) begin
            if (doomed[i]) begin
              present[i] = 1'b0;
              doomed[i] = 1'b0;
            end
          end
          queue_event(4'd0, EV_TICK_DONE, 1'b1);
        end
        default: ;
      endcase
    endfunction

    task check_event(logic [3:0] slot, logic [2:0] code, logic last_flag);
      timer_event_t want;
      if (due_events.size() == 0) begin
        report_mismatch($sformatf("unexpected result slot %0d event %0d last %0b",
                                  slot, code, last_flag));
      end else begin
        want = due_events.pop_front();
        if (slot !== want.slot)
          report_mismatch($sformatf("timer_id_out %0d, wanted %0d", slot, want.slot));
        if (code !== want.code)
          report_mismatch($sformatf("event_res %0d, wanted %0d (slot %0d)",
                                    code, want.code, want.slot));
        if (last_flag !== want.last_flag)
          report_mismatch($sformatf("last %0b, wanted %0b (slot %0d)",
                                    last_flag, want.last_flag, want.slot));
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  operation = OP_TICK;
  logic [3:0]  timer_id = '0;
  logic [15:0] elapsed_ms = '0;
  logic [30:0] initial_remaining = '0;
  logic [30:0] interval_ms = '0;
  logic        periodic = 1'b0;
  logic        result_strobe;
  logic [3:0]  timer_id_out;
  logic [2:0]  event_res;
  logic        last;

  timer_event_board board;
  bit idle_enabled = 1'b1;

  multi_timer_oneshot_periodic DUT (
    .clk               (clk),
    .rst               (rst),
    .start             (start),
    .busy              (busy),
    .operation         (operation),
    .timer_id          (timer_id),
    .elapsed_ms        (elapsed_ms),
    .initial_remaining (initial_remaining),
    .interval_ms       (interval_ms),
    .periodic          (periodic),
    .result_strobe     (result_strobe),
    .timer_id_out      (timer_id_out),
    .event_res         (event_res),
    .last              (last)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && result_strobe) board.check_event(timer_id_out, event_res, last);
  end

  // idle gap with junk on the payload
  task automatic pause_maybe();
    int gap;
    if (idle_enabled && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      start <= 1'b0;
      operation <= 2'($urandom_range(0, 3));
      timer_id <= 4'($urandom());
      elapsed_ms <= 16'($urandom());
      initial_remaining <= 31'($urandom());
      interval_ms <= 31'($urandom());
      periodic <= 1'($urandom());
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_item(logic [1:0] op, logic [3:0] id, logic [15:0] el,
                           logic [30:0] init_rem, logic [30:0] ival, logic per);
    pause_maybe();
    start <= 1'b1;
    operation <= op;
    timer_id <= id;
    elapsed_ms <= el;
    initial_remaining <= init_rem;
    interval_ms <= ival;
    periodic <= per;
    do @(posedge clk); while (busy);
    board.predict_events(op, id, el, init_rem, ival, per);
  endtask

  task automatic start_timer(logic [3:0] id, logic [30:0] init_rem, logic [30:0] ival,
                             logic per);
    send_item(OP_START, id, 16'($urandom()), init_rem, ival, per);
  endtask

  task automatic stop_timer(logic [3:0] id);
    send_item(OP_STOP, id, 16'($urandom()), 31'($urandom()), 31'($urandom()),
              1'($urandom()));
  endtask

  task automatic tick(logic [15:0] el);
    send_item(OP_TICK, 4'($urandom()), el, 31'($urandom()), 31'($urandom()),
              1'($urandom()));
  endtask

  function automatic logic [30:0] pick_time();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2, 3, 4: return 31'($urandom_range(0, 150000));
      default: return 31'($urandom());
    endcase
  endfunction

  function automatic logic [15:0] pick_elapsed();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2, 3: return 16'($urandom_range(0, 300));
      default: return 16'($urandom());
    endcase
  endfunction

  initial begin
    #50_000_000;
    $display("timeout waiting for the block");
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int n_items;
    int pick;
    board = new;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed
    tick(16'd0);
    start_timer(4'd0, 31'd0, 31'd0, 1'b0);
    start_timer(4'd0, 31'd5, 31'd5, 1'b1);
    start_timer(4'd15, 31'h7fff_ffff, 31'h7fff_ffff, 1'b1);
    stop_timer(4'd3);
    start_timer(4'd5, 31'd10, 31'd100, 1'b1);
    start_timer(4'd9, 31'd65535, 31'd0, 1'b0);
    tick(16'd0);
    tick(16'd1);
    stop_timer(4'd5);
    start_timer(4'd5, 31'd1, 31'd1, 1'b0);
    stop_timer(4'd5);
    tick(16'hffff);
    send_item(OP_UNUSED, 4'd15, 16'hffff, 31'h7fff_ffff, 31'h7fff_ffff, 1'b1);
    start_timer(4'd5, 31'd0, 31'h7fff_ffff, 1'b0);
    tick(16'hffff);
    start_timer(4'd7, 31'd1, 31'd2, 1'b1);
    tick(16'hffff);
    tick(16'd0);
    stop_timer(4'd15);
    tick(16'hffff);

    // full table soak: every slot periodic with no reload, a timeout per slot each tick once it has expired
    idle_enabled = 1'b0;
    for (int i = 0; i < SLOTS; i++) stop_timer(4'(i));
    tick(16'd0);
    for (int i = 0; i < SLOTS; i++)
      start_timer(4'(i), 31'($urandom_range(0, 65535)), 31'd0, 1'b1);
    for (int i = 0; i < SOAK_TICKS; i++) tick(16'hffff);
    for (int i = 0; i < SLOTS; i++) stop_timer(4'(i));
    tick(16'd0);

    // random
    n_items = 0;
    while (n_items < 360) begin
      if (n_items >= 310) idle_enabled = 1'b0;
      else idle_enabled = ((n_items / 40) % 4) != 3;
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        start_timer(4'($urandom_range(0, 15)), pick_time(), pick_time(),
                    1'($urandom_range(0, 1)));
        n_items++;
      end else if (pick < 55) begin
        stop_timer(4'($urandom_range(0, 15)));
        n_items++;
      end else if (pick < 96) begin
        tick(pick_elapsed());
        n_items++;
      end else begin
        send_item(OP_UNUSED, 4'($urandom()), 16'($urandom()), 31'($urandom()),
                  31'($urandom()), 1'($urandom()));
      end
    end
    start <= 1'b0;

    while (board.due_events.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (board.mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ multi_timer_oneshot_periodic.f @@
src/mtop_pkg.sv
src/mtop_ctrl.sv
src/mtop_datapath.sv
src/multi_timer_oneshot_periodic.sv
src/mtop_checker.sv
bench/multi_timer_oneshot_periodic_test.sv
